### src/jrdz_pkg.sv
// Package: constants, types and helper functions for the radial dead-zone core.
`timescale 1ns / 1ps
`default_nettype none
package jrdz_pkg;

	localparam int CORDIC_STEPS  = 16;
	localparam int FRACTION_BITS = 15;
	localparam int GUARD_BITS    = 8;
	localparam int DIV_BITS      = FRACTION_BITS + 1;
	// datapath width: Q1.15 scaled by guard bits, with headroom for CORDIC growth
	localparam int DW            = 16 + GUARD_BITS + 3;
	localparam int CFG_IDX_W     = 1;

	localparam logic [31:0] INV_GAIN     = 32'h26DD3B6A;
	localparam logic [31:0] HALF_TURN    = 32'h80000000;
	localparam logic [31:0] QUARTER_TURN = 32'h40000000;

	localparam logic [CFG_IDX_W-1:0] REG_INNER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTER = 1'b1;

	typedef logic signed [DW-1:0] dp_t;

	// how the remapped length is produced
	typedef enum logic [1:0] {
		REMAP_DIV  = 2'd0,
		REMAP_ZERO = 2'd1,
		REMAP_ONE  = 2'd2
	} remap_mode_t;

	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] a;
		begin
			case (i)
				0: a = 32'h20000000;
				1: a = 32'h12E4051E;
				2: a = 32'h09FB385B;
				3: a = 32'h051111D4;
				4: a = 32'h028B0D43;
				5: a = 32'h0145D7E1;
				6: a = 32'h00A2F61E;
				7: a = 32'h00517C55;
				8: a = 32'h0028BE53;
				9: a = 32'h00145F2F;
				10: a = 32'h000A2F98;
				11: a = 32'h000517CC;
				12: a = 32'h00028BE6;
				13: a = 32'h000145F3;
				14: a = 32'h0000A2FA;
				15: a = 32'h0000517D;
				16: a = 32'h000028BE;
				17: a = 32'h0000145F;
				18: a = 32'h00000A30;
				19: a = 32'h00000518;
				20: a = 32'h0000028C;
				21: a = 32'h00000146;
				22: a = 32'h000000A3;
				23: a = 32'h00000051;
				default: a = 32'h0;
			endcase
			return a;
		end
	endfunction

	// signed value times 1/K, rounded half up, arithmetic shift by 30
	function automatic dp_t inv_gain(input dp_t v);
		logic signed [DW+32:0] p;
		begin
			p = $signed({{33{v[DW-1]}}, v}) * $signed({1'b0, INV_GAIN})
				+ $signed((DW+33)'(64'sd1 <<< 29));
			return dp_t'(p >>> 30);
		end
	endfunction

	// round off guard bits and saturate to 16 bits signed
	function automatic logic [15:0] round_sat(input dp_t v);
		dp_t r;
		begin
			r = (v + dp_t'(1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
			if (r > dp_t'(32767))
				return 16'h7FFF;
			else if (r < -dp_t'(32768))
				return 16'h8000;
			else
				return r[15:0];
		end
	endfunction

endpackage
`default_nettype wire

### src/jrdz_stream_if.sv
// Valid/ready stream interfaces for stick samples and corrected results.
`timescale 1ns / 1ps
`default_nettype none
interface jrdz_sample_if;
	logic valid;
	logic ready;
	logic signed [15:0] raw_x;
	logic signed [15:0] raw_y;
	modport source (output valid, raw_x, raw_y, input ready);
	modport sink (input valid, raw_x, raw_y, output ready);
endinterface

interface jrdz_result_if;
	logic valid;
	logic ready;
	logic signed [15:0] corrected_x;
	logic signed [15:0] corrected_y;
	logic [15:0] corrected_magnitude;
	logic signed [15:0] stick_angle;
	modport source (output valid, corrected_x, corrected_y, corrected_magnitude,
		stick_angle, input ready);
	modport sink (input valid, corrected_x, corrected_y, corrected_magnitude,
		stick_angle, output ready);
endinterface
`default_nettype wire

### src/jrdz_cordic_stage.sv
// One pipelined CORDIC micro-rotation (vectoring or rotating mode).
`timescale 1ns / 1ps
`default_nettype none
module jrdz_cordic_stage (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic            vectoring,
	input  wire logic [4:0]      step,
	input  wire jrdz_pkg::dp_t   x_in,
	input  wire jrdz_pkg::dp_t   y_in,
	input  wire logic [31:0]     z_in,
	output jrdz_pkg::dp_t        x_q,
	output jrdz_pkg::dp_t        y_q,
	output logic [31:0]          z_q
);
	jrdz_pkg::dp_t dx, dy;
	logic [31:0]   at;
	logic          up;

	// vectoring steers on sign of y, rotating on sign of residual angle
	always_comb begin
		dx = x_in >>> step;
		dy = y_in >>> step;
		at = jrdz_pkg::atan_turn(int'(step));
		up = vectoring ? !y_in[jrdz_pkg::DW-1] : !z_in[31];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (vectoring) begin
				x_q <= up ? x_in + dy : x_in - dy;
				y_q <= up ? y_in - dx : y_in + dx;
				z_q <= up ? z_in + at : z_in - at;
			end else begin
				x_q <= up ? x_in - dy : x_in + dy;
				y_q <= up ? y_in + dx : y_in - dx;
				z_q <= up ? z_in - at : z_in + at;
			end
		end
	end
endmodule
`default_nettype wire

### src/joystick_radial_dead_zone_core.sv
// Top level: radial dead-zone remap of a stick sample through pipelined CORDICs.
// Throughput: one beat per cycle while not stalled; each CORDIC step and each quotient bit is its own stage.
// A stall freezes the whole pipeline; the input is ready whenever the output
// register is empty or being drained.
// Reset: asynchronous, active low; clears valid bits, inner to 0 and outer to 32768.
`timescale 1ns / 1ps
`default_nettype none
module joystick_radial_dead_zone_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [jrdz_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [15:0]                        cfg_data,
	jrdz_sample_if.sink                             samples,
	jrdz_result_if.source                           results
);
	localparam int NV  = jrdz_pkg::CORDIC_STEPS;
	localparam int ND  = jrdz_pkg::DIV_BITS;
	localparam int FB  = jrdz_pkg::FRACTION_BITS;
	localparam int DW  = jrdz_pkg::DW;
	// stage totals: pre, vectoring, gain, remap setup, divider, rebuild setup, rebuild gain, rotating, out
	localparam int NS  = 2 * NV + ND + 6;
	localparam int QW  = 17;

	logic [15:0] inner_q, outer_q;
	logic        en;
	logic [NS-1:0] vld_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= 16'd0;
			outer_q <= 16'd32768;
		end else if (cfg_we) begin
			unique case (cfg_index)
				jrdz_pkg::REG_INNER: inner_q <= cfg_data;
				jrdz_pkg::REG_OUTER: outer_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global stall: everything advances when the output slot is free or drained
	assign en = !vld_q[NS-1] || results.ready;
	assign samples.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[NS-2:0], samples.valid};
	end

	// stage 1: scale by guard bits, fold the left half plane
	jrdz_pkg::dp_t x_s1, y_s1;
	logic [31:0]   z_s1;
	logic          zero_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= (samples.raw_x == 16'sd0) && (samples.raw_y == 16'sd0);
			if (samples.raw_x[15]) begin
				x_s1 <= -(DW'(samples.raw_x) <<< jrdz_pkg::GUARD_BITS);
				y_s1 <= -(DW'(samples.raw_y) <<< jrdz_pkg::GUARD_BITS);
				z_s1 <= jrdz_pkg::HALF_TURN;
			end else begin
				x_s1 <= DW'(samples.raw_x) <<< jrdz_pkg::GUARD_BITS;
				y_s1 <= DW'(samples.raw_y) <<< jrdz_pkg::GUARD_BITS;
				z_s1 <= 32'd0;
			end
		end
	end

	// vectoring CORDIC chain
	jrdz_pkg::dp_t vx [NV+1];
	jrdz_pkg::dp_t vy [NV+1];
	logic [31:0]   vz [NV+1];
	logic          vzero [NV+1];
	assign vx[0] = x_s1;
	assign vy[0] = y_s1;
	assign vz[0] = z_s1;
	assign vzero[0] = zero_s1;
	for (genvar i = 0; i < NV; i++) begin : g_vec
		jrdz_cordic_stage u_stage (
			.clk(clk), .en(en), .vectoring(1'b1), .step(5'(i)),
			.x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
			.x_q(vx[i+1]), .y_q(vy[i+1]), .z_q(vz[i+1])
		);
		always_ff @(posedge clk) begin
			if (en)
				vzero[i+1] <= vzero[i];
		end
	end

	// gain stage: raw length
	logic [16:0] mag_s2;
	logic [31:0] z_s2;
	jrdz_pkg::dp_t mg;
	assign mg = jrdz_pkg::inv_gain(vx[NV]) + DW'(1 <<< (jrdz_pkg::GUARD_BITS - 1));
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2 <= vzero[NV] ? 17'd0 : 17'(mg >>> jrdz_pkg::GUARD_BITS);
			z_s2   <= vzero[NV] ? 32'd0 : vz[NV];
		end
	end

	// remap setup: decide clamps, prepare division operands
	logic [16:0] num_s3, den_s3;
	jrdz_pkg::remap_mode_t mode_s3;
	logic [31:0] z_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			z_s3   <= z_s2;
			num_s3 <= mag_s2 - 17'(inner_q);
			den_s3 <= 17'(outer_q) - 17'(inner_q);
			if (outer_q <= inner_q)
				mode_s3 <= (mag_s2 > 17'(inner_q)) ? jrdz_pkg::REMAP_ONE : jrdz_pkg::REMAP_ZERO;
			else if (mag_s2 <= 17'(inner_q))
				mode_s3 <= jrdz_pkg::REMAP_ZERO;
			else if (mag_s2 >= 17'(outer_q))
				mode_s3 <= jrdz_pkg::REMAP_ONE;
			else
				mode_s3 <= jrdz_pkg::REMAP_DIV;
		end
	end

	// restoring divider, one quotient bit per stage (num < den when dividing)
	logic [QW-1:0] rem [ND+1];
	logic [QW-1:0] dden [ND+1];
	logic [ND-1:0] quo [ND+1];
	jrdz_pkg::remap_mode_t dmode [ND+1];
	logic [31:0]   dz [ND+1];
	assign rem[0] = num_s3;
	assign dden[0] = den_s3;
	assign quo[0] = '0;
	assign dmode[0] = mode_s3;
	assign dz[0] = z_s3;
	for (genvar k = 0; k < ND; k++) begin : g_div
		logic [QW:0] sh;
		assign sh = {rem[k], 1'b0};
		always_ff @(posedge clk) begin
			if (en) begin
				dden[k+1]  <= dden[k];
				dmode[k+1] <= dmode[k];
				dz[k+1]    <= dz[k];
				if (k == 0) begin
					// first bit: compare without shift gives the integer bit
					if (rem[k] >= dden[k]) begin
						rem[k+1] <= rem[k] - dden[k];
						quo[k+1] <= {quo[k][ND-2:0], 1'b1};
					end else begin
						rem[k+1] <= rem[k];
						quo[k+1] <= {quo[k][ND-2:0], 1'b0};
					end
				end else if (sh >= {1'b0, dden[k]}) begin
					rem[k+1] <= QW'(sh - {1'b0, dden[k]});
					quo[k+1] <= {quo[k][ND-2:0], 1'b1};
				end else begin
					rem[k+1] <= QW'(sh);
					quo[k+1] <= {quo[k][ND-2:0], 1'b0};
				end
			end
		end
	end

	// rebuild setup: length, start x with gain, half-turn fold
	logic [15:0]   len;
	logic [15:0]   len_s4;
	logic [31:0]   z_s4;
	always_comb begin
		case (dmode[ND])
			jrdz_pkg::REMAP_ZERO: len = 16'd0;
			jrdz_pkg::REMAP_ONE:  len = 16'd32768;
			default: len = 16'(quo[ND]) <<< (15 - FB);
		endcase
	end
	always_ff @(posedge clk) begin
		if (en) begin
			len_s4 <= len;
			z_s4   <= dz[ND];
		end
	end

	jrdz_pkg::dp_t x0, x_s5;
	logic [31:0]   zr_s5, z_s5;
	logic [15:0]   len_s5;
	logic          fold;
	assign x0 = jrdz_pkg::inv_gain(DW'({1'b0, len_s4}) <<< jrdz_pkg::GUARD_BITS);
	assign fold = ($signed(z_s4) > $signed(jrdz_pkg::QUARTER_TURN))
		|| ($signed(z_s4) < -$signed(jrdz_pkg::QUARTER_TURN));
	always_ff @(posedge clk) begin
		if (en) begin
			x_s5   <= fold ? -x0 : x0;
			zr_s5  <= fold ? z_s4 + jrdz_pkg::HALF_TURN : z_s4;
			z_s5   <= z_s4;
			len_s5 <= len_s4;
		end
	end

	// rotating CORDIC chain
	jrdz_pkg::dp_t rx [NV+1];
	jrdz_pkg::dp_t ry [NV+1];
	logic [31:0]   rz [NV+1];
	logic [31:0]   ang [NV+1];
	logic [15:0]   rlen [NV+1];
	assign rx[0] = x_s5;
	assign ry[0] = '0;
	assign rz[0] = zr_s5;
	assign ang[0] = z_s5;
	assign rlen[0] = len_s5;
	for (genvar i = 0; i < NV; i++) begin : g_rot
		jrdz_cordic_stage u_stage (
			.clk(clk), .en(en), .vectoring(1'b0), .step(5'(i)),
			.x_in(rx[i]), .y_in(ry[i]), .z_in(rz[i]),
			.x_q(rx[i+1]), .y_q(ry[i+1]), .z_q(rz[i+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				ang[i+1]  <= ang[i];
				rlen[i+1] <= rlen[i];
			end
		end
	end

	// output register
	logic [15:0] cx_s6, cy_s6, mag_s6, ang_s6;
	logic [31:0] ar;
	assign ar = ang[NV] + 32'h8000;
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s6  <= jrdz_pkg::round_sat(rx[NV]);
			cy_s6  <= jrdz_pkg::round_sat(ry[NV]);
			mag_s6 <= rlen[NV];
			ang_s6 <= ar[31:16];
		end
	end

	assign results.valid               = vld_q[NS-1];
	assign results.corrected_x         = cx_s6;
	assign results.corrected_y         = cy_s6;
	assign results.corrected_magnitude = mag_s6;
	assign results.stick_angle         = ang_s6;
endmodule
`default_nettype wire

### src/jrdz_checker.sv
// Port-level checker for the radial dead-zone core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module jrdz_port_props (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] out_mag,
	input wire logic [15:0] out_x
);
	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_mag) && $stable(out_x))
		else $error("result changed while stalled");

	// input is stalled only by a blocked output
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output back-pressure");

	// magnitude never exceeds one
	a_mag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_mag <= 16'd32768)
		else $error("magnitude above one");

	// zero length yields zero x
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_mag == 16'd0 |-> out_x == 16'd0)
		else $error("nonzero x with zero length");
endmodule

bind joystick_radial_dead_zone_core jrdz_port_props u_jrdz_port_props (
	.clk(clk), .arst_n(arst_n),
	.in_valid(samples.valid), .in_ready(samples.ready),
	.out_valid(results.valid), .out_ready(results.ready),
	.out_mag(results.corrected_magnitude), .out_x(results.corrected_x)
);
`default_nettype wire

### verif/jrdz_checker.sv
// Checker: predicts each corrected stick result and compares it with the output beats.
`timescale 1ns / 1ps
`default_nettype none
module jrdz_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	jrdz_sample_if           samples,
	jrdz_result_if           results,
	output int               fail_count,
	output int               pending
);
	typedef struct packed {
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic [15:0]        mag;
		logic signed [15:0] ang;
	} corrected_t;

	localparam int STEPS = 16;
	localparam int GB    = 8;

	logic [15:0] inner_q;
	logic [15:0] outer_q;
	corrected_t  expected_q[$];

	function automatic logic [31:0] arctan_step(input int i);
		logic [31:0] t [0:15];
		t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
			32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
			32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
			32'h0000517D};
		return t[i];
	endfunction

	function automatic longint scale_gain(input longint v);
		return (v * 64'sh26DD3B6A + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic logic [15:0] clip16(input longint v);
		if (v > 32767) return 16'h7FFF;
		if (v < -32768) return 16'h8000;
		return v[15:0];
	endfunction

	function automatic corrected_t remap_stick(input logic signed [15:0] rx,
		input logic signed [15:0] ry, input logic [15:0] inr, input logic [15:0] outr);
		longint x, y, dx, dy, mag, len, t, lo, hi;
		logic [31:0] z, zr;
		logic [31:0] zrnd;
		bit zero;
		corrected_t r;
		zero = (rx == 0) && (ry == 0);
		x = longint'(rx) <<< GB;
		y = longint'(ry) <<< GB;
		z = 0;
		if (x < 0) begin
			x = -x; y = -y; z = 32'h80000000;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i; dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += arctan_step(i);
			end else begin
				x -= dx; y += dy; z -= arctan_step(i);
			end
		end
		if (zero) z = 0;
		mag = zero ? 0 : ((scale_gain(x) + (64'sd1 <<< (GB - 1))) >>> GB);
		lo = inr; hi = outr;
		// radial remap with the degenerate window repaired
		if (hi <= lo) t = (mag > lo) ? 32768 : 0;
		else if (mag <= lo) t = 0;
		else if (mag >= hi) t = 32768;
		else t = ((mag - lo) * 32768) / (hi - lo);
		len = t;
		// rotate back to the raw angle
		x = scale_gain(len <<< GB);
		y = 0;
		zr = z;
		if ($signed(zr) > $signed(32'h40000000) || $signed(zr) < -$signed(32'h40000000)) begin
			zr += 32'h80000000; x = -x;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i; dy = x >>> i;
			if (!zr[31]) begin
				x -= dx; y += dy; zr -= arctan_step(i);
			end else begin
				x += dx; y -= dy; zr += arctan_step(i);
			end
		end
		r.cx = clip16((x + (64'sd1 <<< (GB - 1))) >>> GB);
		r.cy = clip16((y + (64'sd1 <<< (GB - 1))) >>> GB);
		r.mag = len[15:0];
		zrnd = z + 32'h8000;
		r.ang = zrnd[31:16];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	assign pending = expected_q.size();

	// shadow registers, predict on input beat, compare on output beat
	always @(posedge clk or negedge arst_n) begin
		corrected_t e;
		if (!arst_n) begin
			inner_q <= 16'd0;
			outer_q <= 16'd32768;
			fail_count = 0;
			expected_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == jrdz_pkg::REG_INNER) inner_q <= cfg_data;
				else if (cfg_index == jrdz_pkg::REG_OUTER) outer_q <= cfg_data;
			end
			if (results.valid && results.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected beat", 0, 0);
				end else begin
					e = expected_q.pop_front();
					if (results.corrected_x !== e.cx)
						report_mismatch("corrected_x", results.corrected_x, e.cx);
					if (results.corrected_y !== e.cy)
						report_mismatch("corrected_y", results.corrected_y, e.cy);
					if (results.corrected_magnitude !== e.mag)
						report_mismatch("magnitude", results.corrected_magnitude, e.mag);
					if (results.stick_angle !== e.ang)
						report_mismatch("stick_angle", results.stick_angle, e.ang);
				end
			end
			if (samples.valid && samples.ready)
				expected_q.push_back(remap_stick(samples.raw_x, samples.raw_y,
					inner_q, outer_q));
		end
	end
endmodule
`default_nettype wire

### verif/tb_top.sv
// Testbench top: stimulus, configuration phases and verdict for the dead-zone core.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	localparam int LATENCY  = 2 * jrdz_pkg::CORDIC_STEPS + jrdz_pkg::DIV_BITS + 6;
	localparam int WATCHDOG = 20000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;
	int          fail_count;
	int          pending;
	int          src_idle;
	int          snk_idle;
	int          stuck;

	jrdz_sample_if samples ();
	jrdz_result_if results ();

	joystick_radial_dead_zone_core i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .samples(samples.sink), .results(results.source)
	);

	jrdz_checker i_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .samples(samples), .results(results),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver stalls at random
	always @(negedge clk) begin
		results.ready <= ($urandom_range(99) >= snk_idle);
	end

	// watchdog on cycles with no beat
	always @(posedge clk) begin
		if ((samples.valid && samples.ready) || (results.valid && results.ready) || !arst_n)
			stuck <= 0;
		else
			stuck <= stuck + 1;
		if (stuck >= WATCHDOG) begin
			$display("joystick_radial_dead_zone_core verification failed");
			$finish;
		end
	end

	// valid stays high after the beat; the next sample or an idle cycle takes it over
	task automatic send_sample(input logic [15:0] x, input logic [15:0] y);
		while ($urandom_range(99) < src_idle) begin
			samples.valid <= 1'b0;
			@(negedge clk);
		end
		samples.valid <= 1'b1;
		samples.raw_x <= x;
		samples.raw_y <= y;
		@(posedge clk);
		while (!samples.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_and_write(input logic [15:0] inr, input logic [15:0] outr);
		samples.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		cfg_we <= 1'b1; cfg_index <= jrdz_pkg::REG_INNER; cfg_data <= inr;
		@(negedge clk);
		cfg_index <= jrdz_pkg::REG_OUTER; cfg_data <= outr;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// random sample: mostly anywhere, some near the dead-zone edges, some near the centre
	task automatic random_sample(input logic [15:0] inr, input logic [15:0] outr);
		int r;
		int a;
		r = $urandom_range(9);
		if (r < 6) begin
			send_sample(16'($urandom), 16'($urandom));
		end else if (r < 8) begin
			a = (r == 6) ? inr : outr;
			a = a + int'($urandom_range(64)) - 32;
			if (a > 32767) a = 32767;
			if (a < 0) a = 0;
			send_sample(16'($urandom_range(1) ? a : -a), 16'(int'($urandom_range(40)) - 20));
		end else begin
			send_sample(16'(int'($urandom_range(512)) - 256),
				16'(int'($urandom_range(512)) - 256));
		end
	endtask

	initial begin
		logic [15:0] zones [0:5][0:1];
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		samples.valid = 1'b0; samples.raw_x = '0; samples.raw_y = '0;
		results.ready = 1'b0;
		src_idle = 9; snk_idle = 52; stuck = 0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed corners at reset settings
		send_sample(16'h0000, 16'h0000);
		send_sample(16'h7FFF, 16'h0000);
		send_sample(16'h8000, 16'h0000);
		send_sample(16'h0000, 16'h7FFF);
		send_sample(16'h0000, 16'h8000);
		send_sample(16'h7FFF, 16'h7FFF);
		send_sample(16'h8000, 16'h8000);
		send_sample(16'h8000, 16'h7FFF);
		send_sample(16'h7FFF, 16'h8000);
		send_sample(16'hFFFF, 16'h0001);
		send_sample(16'hFFFF, 16'hFFFF);
		send_sample(16'h0001, 16'h0000);
		send_sample(16'hC000, 16'h0001);
		send_sample(16'hC000, 16'hFFFF);
		// degenerate window and over-range registers
		drain_and_write(16'd20000, 16'd10000);
		send_sample(16'd20000, 16'h0000);
		send_sample(16'd20001, 16'h0000);
		send_sample(16'h8000, 16'h8000);
		drain_and_write(16'd46341, 16'd46341);
		send_sample(16'h8000, 16'h8000);
		send_sample(16'h7FFF, 16'h7FFF);
		drain_and_write(16'hFFFF, 16'hFFFF);
		send_sample(16'h8000, 16'h8000);

		zones[0] = '{16'd0, 16'd32768};
		zones[1] = '{16'd4000, 16'd30000};
		zones[2] = '{16'd0, 16'd1};
		zones[3] = '{16'd46341, 16'd0};
		zones[4] = '{16'd8192, 16'd46341};
		zones[5] = '{16'd12000, 16'd12000};
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin src_idle = 52; snk_idle = 9; end
			if (ph == 2) begin src_idle = 0; snk_idle = 0; end
			for (int z = 0; z < 6; z++) begin
				drain_and_write(zones[z][0], zones[z][1]);
				repeat (70) random_sample(zones[z][0], zones[z][1]);
			end
		end

		samples.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		if (fail_count == 0)
			$display("joystick_radial_dead_zone_core verification clean");
		else
			$display("joystick_radial_dead_zone_core verification failed");
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
src/jrdz_pkg.sv
src/jrdz_stream_if.sv
src/jrdz_cordic_stage.sv
src/joystick_radial_dead_zone_core.sv
src/jrdz_checker.sv
verif/jrdz_checker.sv
verif/tb_top.sv
